/* rtl/cau_pkg.sv */
// Shared types, codes and constants of the complex arithmetic unit.
package cau_pkg;

    localparam int FRAC_DIGITS_DEFAULT = 3;
    localparam int PART_W              = 32;
    localparam int MAG_W               = 64;
    localparam int CELLS               = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_SUB = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        op_t                      operation;
        logic signed [PART_W-1:0] a_real;
        logic signed [PART_W-1:0] a_imag;
        logic signed [PART_W-1:0] b_real;
        logic signed [PART_W-1:0] b_imag;
    } operand_t;

    typedef struct packed {
        logic signed [PART_W-1:0] res_real_milli;
        logic signed [PART_W-1:0] res_imag_milli;
        status_t                  status;
    } result_t;

    // One part in the divider chain: partial remainder and a shift word
    // whose upper bits are dividend bits still to come and whose lower bits
    // are quotient bits already formed.
    typedef struct packed {
        logic              neg;
        logic              presat;
        logic [MAG_W-1:0]  rem;
        logic [PART_W-1:0] lowq;
    } part_t;

    typedef struct packed {
        part_t            re;
        part_t            im;
        logic [MAG_W-1:0] den;
        logic             dz;
    } cell_data_t;

    function automatic longint unsigned pow10(input int n);
        longint unsigned s;
        s = 1;
        for (int i = 0; i < n; i++)
        begin
            s = s * 10;
        end
        return s;
    endfunction

    function automatic logic [PART_W-1:0] to_mag(input logic [PART_W-1:0] v);
        return v[PART_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

/* rtl/cau_stream_if.sv */
// Valid/ready stream channel carrying one payload per beat.
interface cau_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/cau_front.sv */
// Front pipeline: sign split, products, signed sums, decimal scaling, range check.
module cau_front #(
    parameter int FRAC_DIGITS = cau_pkg::FRAC_DIGITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    cau_stream_if.sink   operands,
    cau_stream_if.source cells
);
    import cau_pkg::*;

    localparam longint unsigned SCALE   = pow10(FRAC_DIGITS);
    localparam int              SCALE_W = $clog2(SCALE + 1);
    localparam int              HI_W    = PART_W + SCALE_W;
    localparam logic [SCALE_W-1:0] SCALE_V = SCALE_W'(SCALE);

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } sm_t;

    function automatic sm_t sm_add(input sm_t a, input sm_t b);
        sm_t r;
        if (a.neg == b.neg)
        begin
            r.neg = a.neg;
            r.mag = a.mag + b.mag;
        end
        else if (a.mag >= b.mag)
        begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end
        else
        begin
            r.neg = b.neg;
            r.mag = b.mag - a.mag;
        end
        return r;
    endfunction

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    // Stage 0: signs and magnitudes.
    op_t               s0_op_reg;
    logic              s0_sar_reg, s0_sai_reg, s0_sbr_reg, s0_sbi_reg;
    logic [PART_W-1:0] s0_mar_reg, s0_mai_reg, s0_mbr_reg, s0_mbi_reg;

    // Stage 1: product terms.
    sm_t              s1_re_a_reg, s1_re_b_reg, s1_im_a_reg, s1_im_b_reg;
    logic [MAG_W-1:0] s1_den_a_reg, s1_den_b_reg;
    logic             s1_dz_reg;

    // Stage 2: signed sums.
    sm_t              s2_re_reg, s2_im_reg;
    logic [MAG_W-1:0] s2_den_reg;
    logic             s2_dz_reg;

    // Stage 3: scaled partial products.
    logic             s3_re_neg_reg, s3_im_neg_reg;
    logic [HI_W-1:0]  s3_re_pl_reg, s3_re_ph_reg, s3_im_pl_reg, s3_im_ph_reg;
    logic [MAG_W-1:0] s3_den_reg;
    logic             s3_dz_reg;

    // Stage 4: first state of the divider chain.
    cell_data_t s4_reg;

    assign rdy4 = !v4_reg || cells.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign operands.ready = rdy0;
    assign cells.valid    = v4_reg;
    assign cells.payload  = s4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) v0_reg <= operands.valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            s0_op_reg  <= operands.payload.operation;
            s0_sar_reg <= operands.payload.a_real[PART_W-1];
            s0_sai_reg <= operands.payload.a_imag[PART_W-1];
            s0_sbr_reg <= operands.payload.b_real[PART_W-1];
            s0_sbi_reg <= operands.payload.b_imag[PART_W-1];
            s0_mar_reg <= to_mag(operands.payload.a_real);
            s0_mai_reg <= to_mag(operands.payload.a_imag);
            s0_mbr_reg <= to_mag(operands.payload.b_real);
            s0_mbi_reg <= to_mag(operands.payload.b_imag);
        end
    end

    logic [MAG_W-1:0] p_rr, p_ii, p_ri, p_ir, p_br, p_bi;
    sm_t              re_a_next, re_b_next, im_a_next, im_b_next;
    logic [MAG_W-1:0] den_a_next, den_b_next;

    assign p_rr = MAG_W'(s0_mar_reg) * MAG_W'(s0_mbr_reg);
    assign p_ii = MAG_W'(s0_mai_reg) * MAG_W'(s0_mbi_reg);
    assign p_ri = MAG_W'(s0_mar_reg) * MAG_W'(s0_mbi_reg);
    assign p_ir = MAG_W'(s0_mai_reg) * MAG_W'(s0_mbr_reg);
    assign p_br = MAG_W'(s0_mbr_reg) * MAG_W'(s0_mbr_reg);
    assign p_bi = MAG_W'(s0_mbi_reg) * MAG_W'(s0_mbi_reg);

    always_comb
    begin
        den_a_next = MAG_W'(64'h1_0000_0000);
        den_b_next = '0;
        re_a_next  = '{s0_sar_reg, {16'd0, s0_mar_reg, 16'd0}};
        re_b_next  = '{s0_sbr_reg, {16'd0, s0_mbr_reg, 16'd0}};
        im_a_next  = '{s0_sai_reg, {16'd0, s0_mai_reg, 16'd0}};
        im_b_next  = '{s0_sbi_reg, {16'd0, s0_mbi_reg, 16'd0}};
        case (s0_op_reg)
            OP_ADD:
            begin
            end
            OP_SUB:
            begin
                re_b_next.neg = !s0_sbr_reg;
                im_b_next.neg = !s0_sbi_reg;
            end
            OP_MUL:
            begin
                re_a_next = '{s0_sar_reg ^ s0_sbr_reg, p_rr};
                re_b_next = '{!(s0_sai_reg ^ s0_sbi_reg), p_ii};
                im_a_next = '{s0_sar_reg ^ s0_sbi_reg, p_ri};
                im_b_next = '{s0_sbr_reg ^ s0_sai_reg, p_ir};
            end
            OP_DIV:
            begin
                re_a_next  = '{s0_sar_reg ^ s0_sbr_reg, p_rr};
                re_b_next  = '{s0_sai_reg ^ s0_sbi_reg, p_ii};
                im_a_next  = '{s0_sbr_reg ^ s0_sai_reg, p_ir};
                im_b_next  = '{!(s0_sar_reg ^ s0_sbi_reg), p_ri};
                den_a_next = p_br;
                den_b_next = p_bi;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_re_a_reg  <= re_a_next;
            s1_re_b_reg  <= re_b_next;
            s1_im_a_reg  <= im_a_next;
            s1_im_b_reg  <= im_b_next;
            s1_den_a_reg <= den_a_next;
            s1_den_b_reg <= den_b_next;
            s1_dz_reg    <= (s0_op_reg == OP_DIV) && (s0_mbr_reg == '0)
                            && (s0_mbi_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_re_reg  <= sm_add(s1_re_a_reg, s1_re_b_reg);
            s2_im_reg  <= sm_add(s1_im_a_reg, s1_im_b_reg);
            s2_den_reg <= s1_den_a_reg + s1_den_b_reg;
            s2_dz_reg  <= s1_dz_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_re_neg_reg <= s2_re_reg.neg;
            s3_im_neg_reg <= s2_im_reg.neg;
            s3_re_pl_reg  <= HI_W'(s2_re_reg.mag[PART_W-1:0]) * HI_W'(SCALE_V);
            s3_re_ph_reg  <= HI_W'(s2_re_reg.mag[MAG_W-1:PART_W]) * HI_W'(SCALE_V);
            s3_im_pl_reg  <= HI_W'(s2_im_reg.mag[PART_W-1:0]) * HI_W'(SCALE_V);
            s3_im_ph_reg  <= HI_W'(s2_im_reg.mag[MAG_W-1:PART_W]) * HI_W'(SCALE_V);
            s3_den_reg    <= s2_den_reg;
            s3_dz_reg     <= s2_dz_reg;
        end
    end

    // Upper dividend word; the quotient reaches 2^32 when it is not below
    // the divisor.
    logic [HI_W:0] re_hi, im_hi;

    assign re_hi = (HI_W + 1)'(s3_re_ph_reg) + (HI_W + 1)'(s3_re_pl_reg[HI_W-1:PART_W]);
    assign im_hi = (HI_W + 1)'(s3_im_ph_reg) + (HI_W + 1)'(s3_im_pl_reg[HI_W-1:PART_W]);

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_reg.re.neg    <= s3_re_neg_reg;
            s4_reg.re.presat <= MAG_W'(re_hi) >= s3_den_reg;
            s4_reg.re.rem    <= MAG_W'(re_hi);
            s4_reg.re.lowq   <= s3_re_pl_reg[PART_W-1:0];
            s4_reg.im.neg    <= s3_im_neg_reg;
            s4_reg.im.presat <= MAG_W'(im_hi) >= s3_den_reg;
            s4_reg.im.rem    <= MAG_W'(im_hi);
            s4_reg.im.lowq   <= s3_im_pl_reg[PART_W-1:0];
            s4_reg.den       <= s3_den_reg;
            s4_reg.dz        <= s3_dz_reg;
        end
    end

`ifndef SYNTHESIS
    a_accept_fills_stage0: assert property (@(posedge clk) disable iff (!rst_n)
        operands.valid && operands.ready |=> v0_reg)
        else $error("accepted beat did not enter the front pipeline");
`endif

endmodule

/* rtl/cau_div_cell.sv */
// One restoring-division cell: forms one quotient bit of each part per beat.
module cau_div_cell (
    input  logic         clk,
    input  logic         rst_n,
    cau_stream_if.sink   up,
    cau_stream_if.source dn
);
    import cau_pkg::*;

    function automatic part_t step(input part_t p, input logic [MAG_W-1:0] den);
        part_t            r;
        logic [MAG_W:0]   t;
        logic             bit_q;
        t     = {p.rem, p.lowq[PART_W-1]};
        bit_q = t >= {1'b0, den};
        r     = p;
        r.rem = bit_q ? MAG_W'(t - {1'b0, den}) : t[MAG_W-1:0];
        r.lowq = {p.lowq[PART_W-2:0], bit_q};
        return r;
    endfunction

    logic       v_reg;
    cell_data_t d_reg;

    assign up.ready   = !v_reg || dn.ready;
    assign dn.valid   = v_reg;
    assign dn.payload = d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up.ready)
        begin
            v_reg <= up.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.ready)
        begin
            d_reg.re  <= step(up.payload.re, up.payload.den);
            d_reg.im  <= step(up.payload.im, up.payload.den);
            d_reg.den <= up.payload.den;
            d_reg.dz  <= up.payload.dz;
        end
    end

`ifndef SYNTHESIS
    a_beat_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        up.valid && up.ready |=> dn.valid)
        else $error("beat accepted by a divider cell was lost");
`endif

endmodule

/* rtl/complex_arith_unit.sv */
// Top level of the complex arithmetic unit: front pipeline, divider cell row, output register.
//
// The operands channel carries one beat per item: an operation (add,
// multiply, subtract, divide) and two complex values in signed Q16.16.
// The results channel returns one beat per item, in order: real and
// imaginary parts scaled by ten to the FRAC_DIGITS, truncated toward zero
// and saturated to 32 bits, plus a status (ok, divide by zero, overflow).
// An accepted operand beat reaches the results channel through five front
// stages, one cell per quotient bit (32 cells) and the output register.
// Throughput is one item per cycle while the results channel is ready;
// every operation, division included, goes through the same row of cells.
// Each stage holds one beat and moves it on when the next stage is free,
// so a stalled receiver fills the pipeline one stage at a time before the
// operands channel drops ready; bubbles close up while the output waits.
// Reset empties every stage; no item is in flight afterward.
module complex_arith_unit #(
    parameter int FRAC_DIGITS = cau_pkg::FRAC_DIGITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    cau_stream_if.sink   operands,
    cau_stream_if.source results
);
    import cau_pkg::*;

    localparam logic [PART_W-1:0] POS_MAX = {1'b0, {(PART_W - 1){1'b1}}};
    localparam logic [PART_W-1:0] NEG_MAX = {1'b1, {(PART_W - 1){1'b0}}};

    typedef struct packed {
        logic              sat;
        logic [PART_W-1:0] value;
    } fin_t;

    function automatic fin_t finish(input part_t p);
        fin_t r;
        r.sat = p.presat || (p.neg ? (p.lowq > NEG_MAX) : p.lowq[PART_W-1]);
        if (r.sat)
        begin
            r.value = p.neg ? NEG_MAX : POS_MAX;
        end
        else
        begin
            r.value = p.neg ? (~p.lowq + 1'b1) : p.lowq;
        end
        return r;
    endfunction

    cau_stream_if #(.payload_t(cell_data_t)) link [0:CELLS] ();

    cau_front #(.FRAC_DIGITS(FRAC_DIGITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .cells    (link[0])
    );

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        cau_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .up    (link[i]),
            .dn    (link[i + 1])
        );
    end

    logic       out_v_reg;
    result_t    res_reg;
    result_t    res_next;
    fin_t       fin_re, fin_im;
    cell_data_t last;

    assign last   = link[CELLS].payload;
    assign fin_re = finish(last.re);
    assign fin_im = finish(last.im);

    always_comb
    begin
        if (last.dz)
        begin
            res_next.res_real_milli = '0;
            res_next.res_imag_milli = '0;
            res_next.status         = STATUS_DIV_ZERO;
        end
        else
        begin
            res_next.res_real_milli = fin_re.value;
            res_next.res_imag_milli = fin_im.value;
            res_next.status = (fin_re.sat || fin_im.sat) ? STATUS_OVERFLOW : STATUS_OK;
        end
    end

    assign link[CELLS].ready = !out_v_reg || results.ready;
    assign results.valid     = out_v_reg;
    assign results.payload   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (link[CELLS].ready)
        begin
            out_v_reg <= link[CELLS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link[CELLS].ready)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_div_zero_parts: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.payload.status == STATUS_DIV_ZERO
        |-> results.payload.res_real_milli == '0 && results.payload.res_imag_milli == '0)
        else $error("divide by zero result carries nonzero parts");

    a_overflow_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.payload.status == STATUS_OVERFLOW
        |-> results.payload.res_real_milli == POS_MAX
            || results.payload.res_real_milli == NEG_MAX
            || results.payload.res_imag_milli == POS_MAX
            || results.payload.res_imag_milli == NEG_MAX)
        else $error("overflow status without a saturated part");
`endif

endmodule

/* sim/complex_arith_unit_tb.sv */
// Self-checking testbench of the complex arithmetic unit with random idling and backpressure.
module complex_arith_unit_tb;
    import cau_pkg::*;

    localparam int  WATCHDOG_CYCLES = 4000;
    localparam int  LONG_HOLD       = 400;
    localparam int  DRAIN_CYCLES    = 60;
    localparam longint SCALE        = 10 ** FRAC_DIGITS_DEFAULT;

    logic clk;
    logic rst_n;
    int   errors;
    int   quiet_cycles;
    bit   idle_on;
    bit   hold_req;
    bit   done;

    result_t expected_q[$];

    cau_stream_if #(.payload_t(operand_t)) op_if ();
    cau_stream_if #(.payload_t(result_t))  res_if ();

    complex_arith_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (op_if.sink),
        .results  (res_if.source)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Scales an exact fraction to thousandths, truncates toward zero and saturates.
    function automatic logic [PART_W-1:0] to_milli(input logic signed [127:0] num,
                                                   input logic signed [127:0] den,
                                                   inout logic sat);
        logic signed [127:0] k;
        logic signed [127:0] q;
        k = SCALE;
        q = (num * k) / den;
        if (q > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (q < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return q[PART_W-1:0];
    endfunction

    function automatic result_t complex_result(input operand_t x);
        logic signed [127:0] ar, ai, br, bi, nr, ni, den;
        logic                sat;
        result_t             r;
        ar  = x.a_real;
        ai  = x.a_imag;
        br  = x.b_real;
        bi  = x.b_imag;
        den = 128'sd1 <<< 32;
        sat = 1'b0;
        case (x.operation)
            OP_ADD:
            begin
                nr = (ar + br) * 128'sd65536;
                ni = (ai + bi) * 128'sd65536;
            end
            OP_SUB:
            begin
                nr = (ar - br) * 128'sd65536;
                ni = (ai - bi) * 128'sd65536;
            end
            OP_MUL:
            begin
                nr = ar * br - ai * bi;
                ni = ar * bi + ai * br;
            end
            default:
            begin
                if (br == 0 && bi == 0)
                begin
                    r.res_real_milli = '0;
                    r.res_imag_milli = '0;
                    r.status         = STATUS_DIV_ZERO;
                    return r;
                end
                nr  = ar * br + ai * bi;
                ni  = ai * br - ar * bi;
                den = br * br + bi * bi;
            end
        endcase
        r.res_real_milli = to_milli(nr, den, sat);
        r.res_imag_milli = to_milli(ni, den, sat);
        r.status         = sat ? STATUS_OVERFLOW : STATUS_OK;
        return r;
    endfunction

    function automatic logic [PART_W-1:0] rand_part();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom();
            2: return $signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000;
            3: return $signed($urandom_range(0, 32'h3FFF)) - 32'sh2000;
            4: return '0;
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0001_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    task automatic send_item(input operand_t x);
        int  gap;
        bit  rdy;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            op_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_if.valid   <= 1'b1;
        op_if.payload <= x;
        do
        begin
            @(negedge clk);
            rdy = op_if.ready;
            if (rdy)
            begin
                expected_q.push_back(complex_result(x));
            end
            @(posedge clk);
        end
        while (!rdy);
    endtask

    task automatic send_parts(input op_t op, input logic [31:0] ar, input logic [31:0] ai,
                              input logic [31:0] br, input logic [31:0] bi);
        operand_t x;
        x.operation = op;
        x.a_real    = ar;
        x.a_imag    = ai;
        x.b_real    = br;
        x.b_imag    = bi;
        send_item(x);
    endtask

    task automatic send_random(input op_t op);
        send_parts(op, rand_part(), rand_part(), rand_part(), rand_part());
    endtask

    task automatic stop_sending();
        op_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed();
        op_t op;
        op = OP_ADD;
        idle_on = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            op = op_t'(i);
            send_parts(op, 32'h0001_8000, 32'hFFFE_4000, 32'h0000_4000, 32'h0003_0000);
            send_parts(op, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            send_parts(op, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            send_parts(op, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFD);
            send_parts(op, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
        end
        stop_sending();
    endtask

    task automatic test_divide_by_zero();
        send_parts(OP_DIV, 32'h0005_0000, 32'hFFFD_0000, '0, '0);
        send_parts(OP_DIV, '0, '0, '0, '0);
        send_parts(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
        send_parts(OP_DIV, 32'h0001_0000, '0, '0, 32'h0000_0001);
        stop_sending();
    endtask

    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 120; i++)
        begin
            send_random(op_t'($urandom_range(0, 3)));
        end
        stop_sending();
    endtask

    task automatic test_drain_pause();
        idle_on = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            send_random(op_t'($urandom_range(0, 3)));
        end
        stop_sending();
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        for (int i = 0; i < 30; i++)
        begin
            send_random(op_t'($urandom_range(0, 3)));
        end
        stop_sending();
    endtask

    task automatic test_random();
        for (int blk = 0; blk < 15; blk++)
        begin
            idle_on = (blk % 4) != 3;
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_parts(OP_DIV, rand_part(), rand_part(), '0, '0);
                end
                else
                begin
                    send_random(op_t'($urandom_range(0, 3)));
                end
            end
        end
        stop_sending();
    endtask

    // Result sink: random stalls per beat, with one long hold-off on request.
    initial
    begin
        int n;
        bit got;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            n = idle_on ? $urandom_range(0, 16) : 0;
            if (hold_req)
            begin
                n        = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (n > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                got = res_if.valid;
                @(posedge clk);
            end
            while (!got);
        end
    end

    // Result checker and watchdog, sampled between edges.
    initial
    begin
        result_t want;
        result_t got;
        quiet_cycles = 0;
        forever
        begin
            @(negedge clk);
            if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready) || !rst_n)
            begin
                quiet_cycles = 0;
            end
            else if (!done)
            begin
                quiet_cycles++;
            end
            if (rst_n && res_if.valid && res_if.ready)
            begin
                got = res_if.payload;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.res_real_milli !== want.res_real_milli)
                    begin
                        $display("%0t: real part expected %0d actual %0d", $time,
                                 want.res_real_milli, got.res_real_milli);
                        errors++;
                    end
                    if (got.res_imag_milli !== want.res_imag_milli)
                    begin
                        $display("%0t: imaginary part expected %0d actual %0d", $time,
                                 want.res_imag_milli, got.res_imag_milli);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        errors        = 0;
        done          = 1'b0;
        idle_on       = 1'b0;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        op_if.valid   = 1'b0;
        op_if.payload = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_divide_by_zero();
        test_backpressure();
        test_drain_pause();
        test_random();
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/cau_pkg.sv
rtl/cau_stream_if.sv
rtl/cau_front.sv
rtl/cau_div_cell.sv
rtl/complex_arith_unit.sv
sim/complex_arith_unit_tb.sv
